@@ sv/prq_pkg.sv @@
// Shared constants, codes and types for the priority ready-queue scheduler.
`default_nettype none

package prq_pkg;

  // Sizing
  localparam int NUM_TASKS   = 16;
  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;

  // Item field widths
  localparam int KIND_W   = 2;
  localparam int TASK_W   = 4;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  // Derived index and counter widths
  localparam int TASK_IW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HEAD_W    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TREE_N    = 2 ** TASK_IW;

  // Packed stream widths
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = 8;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_PICK
  } state_t;

  // Winner of the resource-holder search
  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] id;
    logic [PRIO_W-1:0] prio;
  } res_pick_t;

  // Flat queue RAM address of slot pos in level lvl
  function automatic logic [ADDR_W-1:0] q_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [HEAD_W-1:0] pos);
    q_addr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(pos);
  endfunction

endpackage

`default_nettype wire

@@ sv/prq_res_pick.sv @@
// Resource-holder search: lowest-numbered holder with the highest nonzero priority.
`default_nettype none

module prq_res_pick (
  input  wire logic [prq_pkg::PRIO_W-1:0] task_prio [prq_pkg::NUM_TASKS],
  input  wire logic                       task_flag [prq_pkg::NUM_TASKS],
  output prq_pkg::res_pick_t              pick
);

  logic [prq_pkg::PRIO_W-1:0] node_prio [2*prq_pkg::TREE_N];
  logic [prq_pkg::TASK_W-1:0] node_id   [2*prq_pkg::TREE_N];

  // Leaves hold the effective priority (zero when no resource held);
  // ties go to the left, i.e. the lower task number.
  always_comb begin
    node_prio[0] = '0;
    node_id[0]   = '0;
    for (int i = 0; i < prq_pkg::TREE_N; i++) begin
      node_id[prq_pkg::TREE_N + i]   = prq_pkg::TASK_W'(i);
      node_prio[prq_pkg::TREE_N + i] = '0;
      if (i < prq_pkg::NUM_TASKS) begin
        if (task_flag[i]) begin
          node_prio[prq_pkg::TREE_N + i] = task_prio[i];
        end
      end
    end
    for (int n = prq_pkg::TREE_N - 1; n >= 1; n--) begin
      if (node_prio[2*n] >= node_prio[2*n+1]) begin
        node_prio[n] = node_prio[2*n];
        node_id[n]   = node_id[2*n];
      end else begin
        node_prio[n] = node_prio[2*n+1];
        node_id[n]   = node_id[2*n+1];
      end
    end
  end

  assign pick.found = (node_prio[1] != '0);
  assign pick.id    = node_id[1];
  assign pick.prio  = node_prio[1];

endmodule

`default_nettype wire

@@ sv/priority_ready_queue_scheduler.sv @@
// Top level: per-level FIFO ready queues in one RAM, plus resource override pick.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready | tuser: kind; tdata: task_id, priority_req,
//          |     |                  |        holds_resource
//  out_    | out | out_tvalid/tready| tdata: next_task, next_valid, status
//
// Each item has an accept step, then a pick step. Accept cycle: level
// head/count and task tables are updated and the queue RAM is read at the
// new top level's head (a write to that same slot in that cycle is
// forwarded). Pick cycle: the RAM read data meets the resource-holder tree
// and the result register is loaded.
// Reset clears heads, counts and task tables at once; the queue RAM is not
// cleared, only slots inside a level's occupied window are ever used.
// A stalled result holds the pick cycle; the result register frees the input
// side once it is loaded.
`default_nettype none

module priority_ready_queue_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [3:0] task_id, [6:4] priority_req, [7] holds_resource
  input  wire logic [prq_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  wire logic [prq_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [3:0] next_task, [4] next_valid, [6:5] status, [7] zero
  output logic [prq_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // ---------------------------------------------------------------- state
  prq_pkg::state_t state_r, state_nxt;

  logic [prq_pkg::HEAD_W-1:0] head_r  [prq_pkg::NUM_LEVELS];
  logic [prq_pkg::HEAD_W-1:0] head_nxt[prq_pkg::NUM_LEVELS];
  logic [prq_pkg::CNT_W-1:0]  count_r  [prq_pkg::NUM_LEVELS];
  logic [prq_pkg::CNT_W-1:0]  count_nxt[prq_pkg::NUM_LEVELS];
  logic [prq_pkg::PRIO_W-1:0] prio_r  [prq_pkg::NUM_TASKS];
  logic [prq_pkg::PRIO_W-1:0] prio_nxt[prq_pkg::NUM_TASKS];
  logic                       flag_r  [prq_pkg::NUM_TASKS];
  logic                       flag_nxt[prq_pkg::NUM_TASKS];

  // Queue RAM: task ids, one LEVEL_DEPTH window per level
  logic [prq_pkg::TASK_W-1:0] qmem [prq_pkg::MEM_DEPTH];
  logic [prq_pkg::TASK_W-1:0] rdata_r;

  logic                         byp_r;
  logic [prq_pkg::TASK_W-1:0]   byp_data_r;
  logic                         ready_valid_r;
  logic [prq_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [prq_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // ---------------------------------------------------------------- input decode
  logic                       acc;
  logic [prq_pkg::KIND_W-1:0] in_kind;
  logic [prq_pkg::TASK_W-1:0] in_task;
  logic [prq_pkg::PRIO_W-1:0] in_prio;
  logic                       in_hold;
  logic                       lvl_ok, task_ok;
  logic [prq_pkg::LVL_W-1:0]  lvl;
  logic [prq_pkg::TASK_IW-1:0] tsk;
  logic [prq_pkg::CNT_W-1:0]  cnt;
  logic [prq_pkg::HEAD_W-1:0] hd;
  logic [prq_pkg::CNT_W:0]    tail_sum;
  logic [prq_pkg::HEAD_W-1:0] tail_pos;

  assign in_tready = (state_r == prq_pkg::ST_IDLE);
  assign acc       = in_tvalid & in_tready;

  assign in_kind = in_tuser[1:0];
  assign in_task = in_tdata[3:0];
  assign in_prio = in_tdata[6:4];
  assign in_hold = in_tdata[7];

  assign lvl_ok  = (32'(in_prio) < prq_pkg::NUM_LEVELS);
  assign task_ok = (32'(in_task) < prq_pkg::NUM_TASKS);
  assign lvl     = prq_pkg::LVL_W'(in_prio);
  assign tsk     = prq_pkg::TASK_IW'(in_task);
  assign cnt     = count_r[lvl];
  assign hd      = head_r[lvl];

  // Tail slot = head + count, wrapped once
  always_comb begin
    tail_sum = (prq_pkg::CNT_W+1)'(hd) + (prq_pkg::CNT_W+1)'(cnt);
    if (tail_sum >= (prq_pkg::CNT_W+1)'(prq_pkg::LEVEL_DEPTH)) begin
      tail_sum = tail_sum - (prq_pkg::CNT_W+1)'(prq_pkg::LEVEL_DEPTH);
    end
    tail_pos = prq_pkg::HEAD_W'(tail_sum);
  end

  // ---------------------------------------------------------------- table update
  logic                       wr_en;
  logic [prq_pkg::ADDR_W-1:0] wr_addr;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    prio_nxt   = prio_r;
    flag_nxt   = flag_r;
    status_nxt = prq_pkg::STATUS_OK;
    wr_en      = 1'b0;
    wr_addr    = prq_pkg::q_addr(lvl, tail_pos);
    case (in_kind)
      prq_pkg::KIND_ADD: begin
        if (lvl_ok && task_ok) begin
          if (cnt >= prq_pkg::CNT_W'(prq_pkg::LEVEL_DEPTH)) begin
            status_nxt = prq_pkg::STATUS_FULL;
          end else begin
            wr_en          = acc;
            prio_nxt[tsk]  = in_prio;
            count_nxt[lvl] = cnt + 1'b1;
          end
        end
      end
      prq_pkg::KIND_REMOVE: begin
        if (lvl_ok) begin
          if (cnt == '0) begin
            status_nxt = prq_pkg::STATUS_EMPTY;
          end else begin
            count_nxt[lvl] = cnt - 1'b1;
            if (32'(hd) == prq_pkg::LEVEL_DEPTH - 1) begin
              head_nxt[lvl] = '0;
            end else begin
              head_nxt[lvl] = hd + 1'b1;
            end
          end
        end
      end
      prq_pkg::KIND_UPDATE: begin
        if (task_ok) begin
          prio_nxt[tsk] = in_prio;
          flag_nxt[tsk] = in_hold;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- top level search
  // Highest non-empty level after this item's update; its head is read.
  logic                       any_ready;
  logic [prq_pkg::LVL_W-1:0]  top_lvl;
  logic [prq_pkg::ADDR_W-1:0] rd_addr;

  always_comb begin
    any_ready = 1'b0;
    top_lvl   = '0;
    for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
      if (count_nxt[i] != '0) begin
        any_ready = 1'b1;
        top_lvl   = prq_pkg::LVL_W'(i);
      end
    end
    rd_addr = prq_pkg::q_addr(top_lvl, head_nxt[top_lvl]);
  end

  // ---------------------------------------------------------------- queue RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      qmem[wr_addr] <= in_task;
    end
    if (acc) begin
      rdata_r <= qmem[rd_addr];
    end
  end

  // Read-during-write on the head slot: an add into an empty top level
  always_ff @(posedge clk) begin
    if (acc) begin
      byp_r         <= wr_en && (wr_addr == rd_addr);
      byp_data_r    <= in_task;
      ready_valid_r <= any_ready;
      status_r      <= status_nxt;
    end
  end

  // ---------------------------------------------------------------- task tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      for (int i = 0; i < prq_pkg::NUM_TASKS; i++) begin
        prio_r[i] <= '0;
        flag_r[i] <= 1'b0;
      end
    end else if (acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      prio_r  <= prio_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // ---------------------------------------------------------------- pick stage
  prq_pkg::res_pick_t res;

  prq_res_pick u_res_pick (
    .task_prio (prio_r),
    .task_flag (flag_r),
    .pick      (res)
  );

  logic [prq_pkg::TASK_W-1:0] ready_task;
  logic                       ready_ok;
  logic [prq_pkg::PRIO_W-1:0] ready_prio;
  logic                       use_res;
  logic                       pick_valid;
  logic [prq_pkg::TASK_W-1:0] pick_task;
  logic                       load_out;

  always_comb begin
    ready_task = byp_r ? byp_data_r : rdata_r;
    ready_ok   = (32'(ready_task) < prq_pkg::NUM_TASKS);
    ready_prio = prio_r[prq_pkg::TASK_IW'(ready_task)];
    // Resource holder overrides when its priority reaches the head's
    use_res    = res.found && (!ready_valid_r || !ready_ok || (res.prio >= ready_prio));
    pick_valid = use_res || ready_valid_r;
    if (use_res) begin
      pick_task = res.id;
    end else if (ready_valid_r) begin
      pick_task = ready_task;
    end else begin
      pick_task = '0;
    end
  end

  assign load_out = (state_r == prq_pkg::ST_PICK) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prq_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = prq_pkg::ST_PICK;
        end
      end
      prq_pkg::ST_PICK: begin
        if (load_out) begin
          state_nxt = prq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {1'b0, status_r, pick_valid, pick_task};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prq_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
